// ===== rtl/core/sigm_pkg.sv =====
// Package for the social inheritance graph step block.
// Holds the item and result types, register indexes, sequencer states and constants.
// Used by the top level and its checker.
package sigm_pkg;

	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PN_THRESH  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PR_THRESH  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RNG_SEED   = 4'd3;

	localparam logic KIND_REGEN = 1'b0;
	localparam logic KIND_BIRTH = 1'b1;

	localparam logic [15:0] HALF_SCALE = 16'h8000;
	localparam logic [31:0] SEED_RESET = 32'd1;
	localparam logic [6:0]  NODES_RESET = 7'd64;
	localparam logic [16:0] PN_RESET = 17'd32768;
	localparam logic [16:0] PR_RESET = 17'd0;

	typedef struct packed {
		logic       kind;
		logic [5:0] newborn;
		logic [5:0] mother;
	} item_t;

	typedef struct packed {
		logic [11:0] degree_sum;
		logic        bad_request;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RG_ROW,
		ST_RG_SWEEP,
		ST_RG_DRAIN,
		ST_RG_WR,
		ST_BR_SWEEP,
		ST_BR_DRAIN,
		ST_BR_WR,
		ST_DONE
	} sigm_state_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_LOAD,
		OP_REGEN,
		OP_BIRTH
	} sigm_op_t;

endpackage

// ===== rtl/core/sigm_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing else in the project.
module sigm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/social_inheritance_graph_step.sv =====
// Top level of the social inheritance graph step block; uses sigm_pkg and sigm_ram.
// A birth item sweeps all MAX_NODES rows and then writes the newborn's row, a rejected
// birth goes straight to its result, and a regenerate item sweeps rows a+1 to n-1 for each row a.
// A sweep does one row read-modify-write per cycle through the single adjacency RAM.
// One item is worked on at a time; a finished result waits in an output register.
// Reset clears the matrix through per-row valid bits at once; no clearing pass is needed.
module social_inheritance_graph_step #(
	parameter int MAX_NODES = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  sigm_pkg::item_t                   item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output sigm_pkg::result_t                 result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sigm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                       cfg_data
);
	import sigm_pkg::*;

	localparam int AW = $clog2(MAX_NODES);
	localparam int CW = AW + 1;
	localparam int KW = (CW > 7) ? CW : 7;

	sigm_state_t state_q, state_d;
	sigm_op_t    op_s1, op_d;

	logic [6:0]  node_count_q;
	logic [16:0] pn_q, pr_q;
	logic [31:0] rng_q, rng_next;
	logic [11:0] deg_q;
	logic [AW-1:0] a_q;
	logic [CW-1:0] b_q;
	logic [MAX_NODES-1:0] valid_q;
	logic [MAX_NODES-1:0] up_q, row_q;
	logic [AW-1:0] nb_q, mo_q;
	logic          bad_q;
	logic [AW-1:0] addr_s1;
	logic          e_s1, rvalid_s1;
	result_t       result_q;
	logic          result_valid_q;

	logic [KW-1:0] nc_ext, nb_ext, mo_ext;
	logic [CW-1:0] n_eff;
	logic          req_bad, accept, load_out, rg_draw, rg_e;
	logic [15:0]   draw;
	logic          birth_draw, birth_e, old_bit;
	logic [16:0]   thr;
	logic [MAX_NODES-1:0] rd_row, wr_row, ram_rdata, ram_wdata;
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;

	sigm_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_adj_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		rng_next = rng_q ^ (rng_q << 13);
		rng_next = rng_next ^ (rng_next >> 17);
		rng_next = rng_next ^ (rng_next << 5);
	end
	assign draw = rng_next[31:16];

	assign nc_ext = KW'(node_count_q);
	assign nb_ext = KW'(item.newborn);
	assign mo_ext = KW'(item.mother);

	always_comb begin
		if (nc_ext < KW'(2)) begin
			n_eff = CW'(2);
		end else if (nc_ext > KW'(MAX_NODES)) begin
			n_eff = CW'(MAX_NODES);
		end else begin
			n_eff = nc_ext[CW-1:0];
		end
	end

	assign req_bad = (nb_ext >= KW'(n_eff)) || (mo_ext >= KW'(n_eff))
		|| (item.newborn == item.mother);
	assign accept = item_valid && !item_stall;
	assign rg_e = (draw < HALF_SCALE);

	assign rd_row = rvalid_s1 ? ram_rdata : '0;
	assign old_bit = rd_row[nb_q];
	assign thr = rd_row[mo_q] ? pn_q : pr_q;
	assign birth_draw = (op_s1 == OP_BIRTH) && ({1'b0, addr_s1} < n_eff);
	assign birth_e = birth_draw && ((addr_s1 == mo_q) || ({1'b0, draw} < thr));

	always_comb begin
		wr_row = rd_row;
		if (op_s1 == OP_REGEN) begin
			wr_row[a_q] = e_s1;
		end else begin
			wr_row[nb_q] = birth_e;
		end
	end

	always_comb begin
		state_d = state_q;
		op_d = OP_NONE;
		item_stall = (state_q != ST_IDLE);
		ram_raddr = b_q[AW-1:0];
		ram_we = (op_s1 == OP_REGEN) || (op_s1 == OP_BIRTH);
		ram_waddr = addr_s1;
		ram_wdata = wr_row;
		rg_draw = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (item.kind == KIND_REGEN) begin
						state_d = ST_RG_ROW;
					end else if (req_bad) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_BR_SWEEP;
					end
				end
			end
			ST_RG_ROW: begin
				ram_raddr = a_q;
				op_d = OP_LOAD;
				state_d = ST_RG_SWEEP;
			end
			ST_RG_SWEEP: begin
				op_d = OP_REGEN;
				rg_draw = 1'b1;
				if (b_q == n_eff - CW'(1)) begin
					state_d = ST_RG_DRAIN;
				end
			end
			ST_RG_DRAIN: begin
				state_d = ST_RG_WR;
			end
			ST_RG_WR: begin
				ram_we = 1'b1;
				ram_waddr = a_q;
				ram_wdata = row_q | up_q;
				if ({1'b0, a_q} + CW'(2) == n_eff) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_RG_ROW;
				end
			end
			ST_BR_SWEEP: begin
				op_d = (b_q[AW-1:0] == nb_q) ? OP_NONE : OP_BIRTH;
				if (b_q == CW'(MAX_NODES - 1)) begin
					state_d = ST_BR_DRAIN;
				end
			end
			ST_BR_DRAIN: begin
				state_d = ST_BR_WR;
			end
			ST_BR_WR: begin
				ram_we = 1'b1;
				ram_waddr = nb_q;
				ram_wdata = up_q;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!result_valid_q || !result_stall) begin
					load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_s1 <= OP_NONE;
			node_count_q <= NODES_RESET;
			pn_q <= PN_RESET;
			pr_q <= PR_RESET;
			rng_q <= SEED_RESET;
			deg_q <= '0;
			a_q <= '0;
			b_q <= '0;
			valid_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_s1 <= op_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_NODE_COUNT: node_count_q <= cfg_data[6:0];
					CFG_PN_THRESH:  pn_q <= cfg_data[16:0];
					CFG_PR_THRESH:  pr_q <= cfg_data[16:0];
					CFG_RNG_SEED:   rng_q <= (cfg_data == '0) ? SEED_RESET : cfg_data;
					default: ;
				endcase
			end
			if (rg_draw || birth_draw) begin
				rng_q <= rng_next;
			end
			if (rg_draw) begin
				deg_q <= deg_q + {10'd0, rg_e, 1'b0};
				b_q <= b_q + CW'(1);
			end
			if (op_s1 == OP_BIRTH) begin
				deg_q <= deg_q + {10'd0, birth_e, 1'b0} - {10'd0, old_bit, 1'b0};
			end
			if (state_q == ST_BR_SWEEP) begin
				b_q <= b_q + CW'(1);
			end
			if (state_q == ST_RG_ROW) begin
				b_q <= {1'b0, a_q} + CW'(1);
			end
			if (state_q == ST_RG_WR) begin
				a_q <= a_q + AW'(1);
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (accept) begin
				a_q <= '0;
				b_q <= '0;
				if (item.kind == KIND_REGEN) begin
					valid_q <= '0;
					deg_q <= '0;
				end
			end
			if (load_out) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rvalid_s1 <= valid_q[ram_raddr];
		addr_s1 <= ram_raddr;
		e_s1 <= rg_e;
		if (rg_draw) begin
			up_q[b_q[AW-1:0]] <= rg_e;
		end
		if (op_s1 == OP_BIRTH) begin
			up_q[addr_s1] <= birth_e;
		end
		if (op_s1 == OP_LOAD) begin
			row_q <= rd_row;
		end
		if (state_q == ST_RG_ROW) begin
			up_q <= '0;
		end
		if (accept) begin
			up_q <= '0;
			nb_q <= nb_ext[AW-1:0];
			mo_q <= mo_ext[AW-1:0];
			bad_q <= (item.kind == KIND_BIRTH) && req_bad;
		end
		if (load_out) begin
			result_q.degree_sum <= deg_q;
			result_q.bad_request <= bad_q;
		end
	end

	assign cfg_ready = 1'b1;
	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

// ===== rtl/core/sigm_chk.sv =====
// Port-level checker for the social inheritance graph step block, bound to the top level.
// Depends on sigm_pkg for the result type.
module sigm_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input logic              result_valid,
	input logic              result_stall,
	input sigm_pkg::result_t result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result item changed or dropped");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("block took a second item while the first was in work");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && !result_valid |=> !result_valid)
		else $error("result item appeared in the cycle after acceptance");

	a_degree_even: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !result.degree_sum[0])
		else $error("degree sum of an undirected graph is odd");

endmodule

bind social_inheritance_graph_step sigm_chk u_sigm_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

// ===== sim/social_inheritance_graph_step_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for social_inheritance_graph_step, built on sigm_pkg and the RTL.
// A clocked driver and monitor move items with random idling; an internal graph predictor
// with its own xorshift generator supplies the expected degree sum of every item.
module social_inheritance_graph_step_tb;
	import sigm_pkg::*;

	localparam int MAX_NODES = 64;
	localparam int QUIET_LIMIT = 12000;
	localparam int PHASES = 14;
	localparam int PHASE_ITEMS = 110;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	logic [MAX_NODES-1:0] adj [MAX_NODES];
	logic [11:0] degree_now = '0;
	logic [31:0] chain = SEED_RESET;
	logic [6:0] nodes_reg = NODES_RESET;
	logic [16:0] pn_reg = PN_RESET;
	logic [16:0] pr_reg = PR_RESET;

	item_t pending_items [$];
	result_t awaited_sums [$];
	result_t predicted;
	result_t want;
	int gap_left = 0;
	int stall_left = 0;
	int idle_pct = 0;
	bit calm = 1'b0;
	int errors = 0;
	int quiet_cycles = 0;
	bit timed_out = 1'b0;

	social_inheritance_graph_step #(.MAX_NODES(MAX_NODES)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		for (int r = 0; r < MAX_NODES; r++) adj[r] = '0;
	end

	function automatic int eff_nodes(logic [6:0] raw);
		if (raw < 2) return 2;
		if (raw > MAX_NODES) return MAX_NODES;
		return int'(raw);
	endfunction

	function automatic logic [15:0] xorshift_draw();
		logic [31:0] x;
		x = chain;
		x = x ^ (x << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		chain = x;
		return x[31:16];
	endfunction

	task automatic add_item(input item_t it);
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic advance_graph(input item_t it, output result_t res);
		int n;
		int sum;
		logic [15:0] d;
		logic [16:0] th;
		n = eff_nodes(nodes_reg);
		res.bad_request = 1'b0;
		if (it.kind == KIND_REGEN) begin
			for (int a = 0; a < MAX_NODES; a++) adj[a] = '0;
			for (int a = 0; a < n; a++) begin
				for (int b = a + 1; b < n; b++) begin
					d = xorshift_draw();
					if (d < HALF_SCALE) begin
						adj[a][b] = 1'b1;
						adj[b][a] = 1'b1;
					end
				end
			end
		end else if (it.newborn >= n || it.mother >= n || it.newborn == it.mother) begin
			res.bad_request = 1'b1;
		end else begin
			adj[it.newborn] = '0;
			for (int b = 0; b < MAX_NODES; b++) adj[b][it.newborn] = 1'b0;
			adj[it.newborn][it.mother] = 1'b1;
			adj[it.mother][it.newborn] = 1'b1;
			for (int b = 0; b < n; b++) begin
				if (b != it.newborn) begin
					th = adj[b][it.mother] ? pn_reg : pr_reg;
					d = xorshift_draw();
					if ({1'b0, d} < th) begin
						adj[it.newborn][b] = 1'b1;
						adj[b][it.newborn] = 1'b1;
					end
				end
			end
		end
		if (res.bad_request == 1'b0) begin
			sum = 0;
			for (int a = 0; a < MAX_NODES; a++) sum += $countones(adj[a]);
			degree_now = 12'(sum);
		end
		res.degree_sum = degree_now;
	endtask

	// Items are loaded from the pending queue and predicted when the block takes them.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				advance_graph(item, predicted);
				awaited_sums.insert(awaited_sums.size(), predicted);
			end
			if (!(item_valid && item_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					item_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					item <= pending_items.pop_front();
					item_valid <= 1'b1;
					gap_left = (!calm && $urandom_range(99) < idle_pct) ? $urandom_range(1, 3) : 0;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	task automatic note_mismatch(input string what, input int expected_val, input int actual_val);
		if (errors < 10)
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $realtime, what,
				expected_val, actual_val);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (awaited_sums.size() == 0) begin
					note_mismatch("unexpected result, degree_sum", -1, result.degree_sum);
				end else begin
					want = awaited_sums.pop_front();
					if (result.degree_sum !== want.degree_sum)
						note_mismatch("degree_sum", want.degree_sum, result.degree_sum);
					if (result.bad_request !== want.bad_request)
						note_mismatch("bad_request", want.bad_request, result.bad_request);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else if (!calm && $urandom_range(99) < idle_pct) begin
				stall_left = $urandom_range(0, 2);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_NODE_COUNT: nodes_reg = data[6:0];
			CFG_PN_THRESH: pn_reg = data[16:0];
			CFG_PR_THRESH: pr_reg = data[16:0];
			CFG_RNG_SEED: chain = (data == 32'd0) ? SEED_RESET : data;
			default: ;
		endcase
	endtask

	// The block is idle once the queue, the input port and the expected results are all empty.
	task automatic settle();
		do @(negedge clk);
		while (pending_items.size() != 0 || item_valid || awaited_sums.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [16:0] pick_threshold();
		case ($urandom_range(4))
			0: return 17'd0;
			1: return 17'd65536;
			2: return 17'($urandom_range(65537, 131071));
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	task automatic queue_random(input int count, input int regen_pct);
		item_t it;
		int n;
		int pick;
		n = eff_nodes(nodes_reg);
		for (int i = 0; i < count; i++) begin
			it = item_t'($urandom);
			it.kind = ($urandom_range(99) < regen_pct) ? KIND_REGEN : KIND_BIRTH;
			pick = $urandom_range(99);
			if (it.kind == KIND_BIRTH && pick < 85) begin
				it.newborn = 6'($urandom_range(n - 1));
				it.mother = 6'($urandom_range(n - 2));
				if (it.mother >= it.newborn) it.mother = it.mother + 6'd1;
			end else if (it.kind == KIND_BIRTH && pick < 92) begin
				it.mother = it.newborn;
			end
			add_item(it);
		end
	endtask

	initial begin
		logic [6:0] nodes_pick;
		int n;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		fork
			begin
				// Reset values of the registers, extreme indexes and a full-size regenerate.
				idle_pct = 30;
				add_item('{KIND_BIRTH, 6'd0, 6'd63});
				add_item('{KIND_BIRTH, 6'd63, 6'd0});
				add_item('{KIND_BIRTH, 6'd5, 6'd5});
				add_item('{KIND_REGEN, 6'd63, 6'd63});
				add_item('{KIND_BIRTH, 6'd1, 6'd2});
				add_item('{KIND_BIRTH, 6'd62, 6'd1});
				settle();
				// Small network, thresholds at and above full scale and a zero seed.
				cfg_write(CFG_NODE_COUNT, 32'd10);
				cfg_write(CFG_PN_THRESH, 32'd65536);
				cfg_write(CFG_PR_THRESH, 32'd131071);
				cfg_write(CFG_RNG_SEED, 32'd0);
				add_item('{KIND_BIRTH, 6'd63, 6'd0});
				add_item('{KIND_BIRTH, 6'd3, 6'd10});
				add_item('{KIND_BIRTH, 6'd9, 6'd0});
				add_item('{KIND_REGEN, 6'd0, 6'd0});
				add_item('{KIND_BIRTH, 6'd0, 6'd9});
				settle();
				// A node count below the minimum acts as two nodes.
				cfg_write(CFG_NODE_COUNT, 32'd1);
				cfg_write(CFG_PN_THRESH, 32'd0);
				cfg_write(CFG_PR_THRESH, 32'd0);
				cfg_write(CFG_RNG_SEED, 32'hFFFF_FFFF);
				add_item('{KIND_REGEN, 6'd21, 6'd42});
				add_item('{KIND_BIRTH, 6'd0, 6'd1});
				add_item('{KIND_BIRTH, 6'd1, 6'd0});
				add_item('{KIND_BIRTH, 6'd0, 6'd2});
				add_item('{KIND_BIRTH, 6'd1, 6'd1});
				settle();
				// A node count above the maximum acts as the maximum.
				cfg_write(CFG_NODE_COUNT, 32'd127);
				cfg_write(CFG_PN_THRESH, 32'd131071);
				cfg_write(CFG_PR_THRESH, 32'd65536);
				add_item('{KIND_BIRTH, 6'd42, 6'd21});
				add_item('{KIND_BIRTH, 6'd21, 6'd42});
				add_item('{KIND_BIRTH, 6'd63, 6'd62});
				settle();

				for (int p = 0; p < PHASES; p++) begin
					case ($urandom_range(5))
						0: nodes_pick = 7'd64;
						1: nodes_pick = 7'($urandom_range(2, 8));
						2: nodes_pick = 7'($urandom_range(2, 64));
						3: nodes_pick = 7'($urandom_range(0, 1));
						4: nodes_pick = 7'($urandom_range(65, 127));
						default: nodes_pick = 7'($urandom_range(9, 32));
					endcase
					cfg_write(CFG_NODE_COUNT, {25'd0, nodes_pick});
					cfg_write(CFG_PN_THRESH, {15'd0, pick_threshold()});
					cfg_write(CFG_PR_THRESH, {15'd0, pick_threshold()});
					if ($urandom_range(1))
						cfg_write(CFG_RNG_SEED, ($urandom_range(9) == 0) ? 32'd0 : $urandom);
					case ($urandom_range(2))
						0: idle_pct = 0;
						1: idle_pct = 20;
						default: idle_pct = 50;
					endcase
					if (p == PHASES - 1) calm = 1'b1;
					n = eff_nodes(nodes_reg);
					queue_random(PHASE_ITEMS, (n > 24) ? 2 : 15);
					settle();
				end
				repeat (100) @(posedge clk);
			end
			begin
				while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
				timed_out = 1'b1;
			end
		join_any
		if (timed_out) begin
			$display("Regression FAIL");
		end else if (errors == 0 && awaited_sums.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
